/* sv/trfe_pkg.sv */
`default_nettype none
package trfe_pkg;

   localparam int unsigned DurWidth   = 14;
   localparam int unsigned RepWidth   = 8;
   localparam int unsigned SlotWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;

   // slot that holds the sync pulse, after the twelve trits
   localparam logic [SlotWidth-1:0] SYNC_SLOT = 4'd12;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_SHORT_TICKS    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_TICKS     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_GAP_TICKS = 2'd2;

   localparam logic [DurWidth-1:0] SHORT_TICKS_RESET    = 14'd222;
   localparam logic [DurWidth-1:0] LONG_TICKS_RESET     = 14'd445;
   localparam logic [DurWidth-1:0] SYNC_GAP_TICKS_RESET = 14'd10656;

   typedef struct packed {
      logic                mode;
      logic [1:0]          house;
      logic [1:0]          unit;
      logic                switch_on;
      logic [RepWidth-1:0] repeat_count;
   } req_word_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic burst_done;
   } rsp_word_type;

   typedef struct packed {
      logic [DurWidth-1:0] short_ticks;
      logic [DurWidth-1:0] long_ticks;
      logic [DurWidth-1:0] sync_gap_ticks;
   } cfg_type;

endpackage
`default_nettype wire

/* sv/trfe_csr.sv */
`default_nettype none
module trfe_csr
   import trfe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [DurWidth-1:0]    csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHORT_TICKS:    cfg_in.short_ticks    = csr_data;
            CSR_LONG_TICKS:     cfg_in.long_ticks     = csr_data;
            CSR_SYNC_GAP_TICKS: cfg_in.sync_gap_ticks = csr_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_ticks    <= SHORT_TICKS_RESET;
         cfg_ff.long_ticks     <= LONG_TICKS_RESET;
         cfg_ff.sync_gap_ticks <= SYNC_GAP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* sv/trfe_core.sv */
`default_nettype none
module trfe_core
   import trfe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_word_type word,
   input  wire cfg_type      cfg,
   output rsp_word_type      rsp
);

   logic                 sending_ff, sending_in;
   logic [RepWidth-1:0]  reps_ff, reps_in;
   logic [SlotWidth-1:0] slot_ff, slot_in;
   logic                 pulse_ff, pulse_in;
   logic                 low_ff, low_in;
   logic [DurWidth-1:0]  cnt_ff, cnt_in;
   logic [4:0]           code_ff, code_in;

   logic                 trit;
   logic [SlotWidth-1:0] unit_slot;
   logic [DurWidth-1:0]  dur;
   logic [DurWidth-1:0]  dur_eff;
   logic [DurWidth:0]    cnt_inc;
   logic                 phase_end;
   logic [RepWidth-1:0]  reps_dec;

   // one-cold house and unit, fixed 1001, then activation
   assign unit_slot = slot_ff - 4'd4;
   always_comb begin
      if (slot_ff < 4'd4) begin
         trit = (slot_ff[1:0] != code_ff[1:0]);
      end else if (slot_ff < 4'd7) begin
         trit = (unit_slot[1:0] != code_ff[3:2]);
      end else if (slot_ff == 4'd7 || slot_ff == 4'd10) begin
         trit = 1'b1;
      end else if (slot_ff < 4'd10) begin
         trit = 1'b0;
      end else begin
         trit = code_ff[4];
      end
   end

   always_comb begin
      if (slot_ff >= SYNC_SLOT) begin
         dur = low_ff ? cfg.sync_gap_ticks : cfg.short_ticks;
      end else if (trit && pulse_ff) begin
         dur = low_ff ? cfg.short_ticks : cfg.long_ticks;
      end else begin
         dur = low_ff ? cfg.long_ticks : cfg.short_ticks;
      end
   end

   assign dur_eff   = (dur == '0) ? {{(DurWidth-1){1'b0}}, 1'b1} : dur;
   assign cnt_inc   = {1'b0, cnt_ff} + {{DurWidth{1'b0}}, 1'b1};
   assign phase_end = cnt_inc >= {1'b0, dur_eff};
   assign reps_dec  = reps_ff - {{(RepWidth-1){1'b0}}, 1'b1};

   always_comb begin
      sending_in = sending_ff;
      reps_in    = reps_ff;
      slot_in    = slot_ff;
      pulse_in   = pulse_ff;
      low_in     = low_ff;
      cnt_in     = cnt_ff;
      code_in    = code_ff;
      rsp        = '0;
      if (word.mode) begin
         if (!sending_ff) begin
            code_in    = {word.switch_on, word.unit, word.house};
            slot_in    = '0;
            pulse_in   = 1'b0;
            low_in     = 1'b0;
            cnt_in     = '0;
            reps_in    = word.repeat_count;
            sending_in = (word.repeat_count != '0);
            rsp.line_level = (word.repeat_count != '0);
         end else begin
            rsp.line_level = !low_ff;
         end
         rsp.busy_res = sending_in;
      end else if (sending_ff) begin
         rsp.line_level = !low_ff;
         rsp.busy_res   = 1'b1;
         if (phase_end) begin
            cnt_in = '0;
            if (!low_ff) begin
               low_in = 1'b1;
            end else begin
               low_in = 1'b0;
               if (slot_ff >= SYNC_SLOT) begin
                  slot_in  = '0;
                  pulse_in = 1'b0;
                  reps_in  = reps_dec;
                  if (reps_dec == '0) begin
                     sending_in     = 1'b0;
                     rsp.burst_done = 1'b1;
                  end
               end else if (!pulse_ff) begin
                  pulse_in = 1'b1;
               end else begin
                  pulse_in = 1'b0;
                  slot_in  = slot_ff + 4'd1;
               end
            end
         end else begin
            cnt_in = cnt_inc[DurWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         reps_ff    <= '0;
         slot_ff    <= '0;
         pulse_ff   <= 1'b0;
         low_ff     <= 1'b0;
         cnt_ff     <= '0;
         code_ff    <= '0;
      end else if (fire) begin
         sending_ff <= sending_in;
         reps_ff    <= reps_in;
         slot_ff    <= slot_in;
         pulse_ff   <= pulse_in;
         low_ff     <= low_in;
         cnt_ff     <= cnt_in;
         code_ff    <= code_in;
      end
   end

endmodule
`default_nettype wire

/* sv/tristate_remote_frame_encoder.sv */
// path: a word taken on req passes the input register, then the result register, to rsp,
//    and waits there while rsp is stalled
// throughput: one word per cycle while rsp is not stalled; the encoder state loop is combinational
// reset: synchronous, active high; clears both pipeline valids and the burst state
//    (idle) and loads the duration registers with 222 / 445 / 10656 ticks
`default_nettype none
module tristate_remote_frame_encoder
   import trfe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_word_type           req_data,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_word_type                rsp_data,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [DurWidth-1:0]    csr_data
);

   // input register
   logic         in_vld_ff, in_vld_in;
   req_word_type in_word_ff;

   // result register
   logic         out_vld_ff, out_vld_in;
   rsp_word_type out_word_ff;

   logic         req_take;
   logic         out_free;
   logic         fire;
   rsp_word_type core_rsp;
   cfg_type      cfg;

   // the result register can load when empty or being drained this cycle
   assign out_free = !out_vld_ff || !rsp_stall;
   // the word in the input register goes through the encoder and into the result register
   assign fire     = in_vld_ff && out_free;
   // input register is refilled whenever its word moves on or it is empty
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !out_free);
   assign out_vld_in = out_free ? in_vld_ff : out_vld_ff;

   trfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // burst sequencer: state advances only when a word fires
   trfe_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .word  (in_word_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data;
      end
      if (fire) begin
         out_word_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

endmodule
`default_nettype wire

/* sv/trfe_checker.sv */
`default_nettype none
module trfe_checker
   import trfe_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // end of burst is reported while still busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.burst_done |-> rsp_data.busy_res)
      else $error("burst_done without busy_res");

   // the line is only keyed during a burst
   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_level |-> rsp_data.busy_res)
      else $error("line high while idle");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an accepted word with an empty result register is answered through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !req_stall && req_valid && !rsp_valid && !rsp_stall |=> ##1 rsp_valid)
      else $error("rsp missing after accepted word");

endmodule

bind tristate_remote_frame_encoder trfe_checker u_trfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* bench/tristate_remote_frame_encoder_test.sv */
`timescale 1ns / 1ps

module tristate_remote_frame_encoder_test;
   import trfe_pkg::*;

   // request word kinds
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   // register index that maps to no register
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE = 2'd3;

   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PHASE_WORDS  = 110;
   localparam int unsigned MAX_REPORTS  = 50;
   localparam int unsigned SETTLE_TICKS = 20;

   // dut ports, all driven from time zero
   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [DurWidth-1:0]    csr_data  = '0;

   // stimulus side
   req_word_type pending_words[$];
   rsp_word_type expected_line_q[$];
   int unsigned  words_queued = 0;
   int unsigned  tx_gap_pct   = 0;
   int unsigned  rx_stall_pct = 0;
   int unsigned  hold_go      = 0;
   int unsigned  hold_seen    = 0;
   int unsigned  hold_left    = 0;
   logic         req_fired    = 1'b0;
   int unsigned  mismatches   = 0;

   // encoder shadow: duration registers
   logic [DurWidth-1:0] dur_short = SHORT_TICKS_RESET;
   logic [DurWidth-1:0] dur_long  = LONG_TICKS_RESET;
   logic [DurWidth-1:0] dur_sync  = SYNC_GAP_TICKS_RESET;

   // encoder shadow: burst state
   logic                 burst_on   = 1'b0;
   logic [RepWidth-1:0]  reps_left  = '0;
   logic [SlotWidth-1:0] trit_slot  = '0;
   logic                 pulse_half = 1'b0;
   logic                 low_phase  = 1'b0;
   logic [DurWidth-1:0]  phase_ticks_done = '0;
   logic [1:0]           held_house = '0;
   logic [1:0]           held_unit  = '0;
   logic                 held_on    = 1'b0;

   tristate_remote_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // a zero duration still lasts one tick
   function automatic int unsigned ticks_of(logic [DurWidth-1:0] d);
      return (d == 0) ? 1 : d;
   endfunction

   // house and unit are one-cold, then 1001, then the on/off trit
   function automatic logic trit_of(logic [SlotWidth-1:0] s, logic [1:0] house,
                                    logic [1:0] unit, logic on);
      if (s < 4) return s != house;
      if (s < 7) return (s - 4) != unit;
      if (s == 7 || s == 10) return 1'b1;
      if (s < 10) return 1'b0;
      return on;
   endfunction

   // length of the phase the encoder is in now
   function automatic int unsigned current_phase_ticks();
      logic long_high;
      if (trit_slot >= SYNC_SLOT) return low_phase ? ticks_of(dur_sync) : ticks_of(dur_short);
      long_high = trit_of(trit_slot, held_house, held_unit, held_on) && pulse_half;
      if (long_high) return low_phase ? ticks_of(dur_short) : ticks_of(dur_long);
      return low_phase ? ticks_of(dur_long) : ticks_of(dur_short);
   endfunction

   // advance the shadow encoder by one request word, return the line word it gives
   function automatic rsp_word_type encode_tick(req_word_type w);
      rsp_word_type r;
      r = '0;
      if (w.mode == MODE_START) begin
         // a start while busy changes nothing
         if (!burst_on) begin
            held_house = w.house;
            held_unit  = w.unit;
            held_on    = w.switch_on;
            trit_slot  = '0;
            pulse_half = 1'b0;
            low_phase  = 1'b0;
            phase_ticks_done = '0;
            reps_left  = w.repeat_count;
            burst_on   = w.repeat_count != 0;
         end
         r.line_level = burst_on && !low_phase;
         r.busy_res   = burst_on;
      end else if (burst_on) begin
         r.line_level = !low_phase;
         r.busy_res   = 1'b1;
         if (phase_ticks_done + 1 >= current_phase_ticks()) begin
            phase_ticks_done = '0;
            if (!low_phase) begin
               low_phase = 1'b1;
            end else begin
               low_phase = 1'b0;
               if (trit_slot >= SYNC_SLOT) begin
                  // end of frame: next repetition or done
                  trit_slot  = '0;
                  pulse_half = 1'b0;
                  reps_left  = reps_left - 1'b1;
                  if (reps_left == 0) begin
                     burst_on     = 1'b0;
                     r.burst_done = 1'b1;
                  end
               end else if (!pulse_half) begin
                  pulse_half = 1'b1;
               end else begin
                  pulse_half = 1'b0;
                  trit_slot  = trit_slot + 1'b1;
               end
            end
         end else begin
            phase_ticks_done = phase_ticks_done + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic req_word_type make_word(logic mode, logic [1:0] house, logic [1:0] unit,
                                              logic on, logic [RepWidth-1:0] reps);
      req_word_type w;
      w.mode         = mode;
      w.house        = house;
      w.unit         = unit;
      w.switch_on    = on;
      w.repeat_count = reps;
      return w;
   endfunction

   // all fields random except the kind
   function automatic req_word_type random_word(logic mode);
      return make_word(mode, $urandom_range(3), $urandom_range(3), $urandom_range(1),
                       $urandom_range(255));
   endfunction

   // driver: next word offered at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
            req_data  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // every accepted request word yields exactly one expected line word
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) expected_line_q.push_back(encode_tick(req_data));
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_go) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
      end
   end

   // monitor: compare each accepted line word with the oldest expectation
   always @(posedge clock) begin : check_line
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_line_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: line word with none expected, actual level %0b busy %0b done %0b",
                        $time, rsp_data.line_level, rsp_data.busy_res, rsp_data.burst_done);
         end else begin
            want = expected_line_q.pop_front();
            if (rsp_data.line_level !== want.line_level || rsp_data.busy_res !== want.busy_res ||
                rsp_data.burst_done !== want.burst_done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: expected level %0b busy %0b done %0b, actual %0b %0b %0b",
                           $time, want.line_level, want.busy_res, want.burst_done,
                           rsp_data.line_level, rsp_data.busy_res, rsp_data.burst_done);
            end
         end
      end
   end

   // sender holds until every word was taken and answered
   task automatic wait_all_answered();
      while (pending_words.size() != 0 || req_valid || expected_line_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write, mirrored into the shadow at the handshake edge
   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, logic [DurWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SHORT_TICKS:    dur_short = value;
         CSR_LONG_TICKS:     dur_long  = value;
         CSR_SYNC_GAP_TICKS: dur_sync  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_word(req_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // a start followed by exactly enough ticks to finish the burst,
   // with ignored starts sprinkled while it runs
   task automatic queue_burst();
      int unsigned reps;
      int unsigned frame;
      int unsigned total;
      int unsigned pick;
      pick = $urandom_range(99);
      reps = (pick < 70) ? 1 : ((pick < 95) ? 2 : 3);
      push_word(make_word(MODE_START, $urandom_range(3), $urandom_range(3), $urandom_range(1),
                          reps));
      // every trit is short+long twice, whatever its value
      frame = 24 * (ticks_of(dur_short) + ticks_of(dur_long)) + ticks_of(dur_short) +
              ticks_of(dur_sync);
      total = reps * frame;
      for (int unsigned i = 1; i <= total; i++) begin
         push_word(random_word(MODE_TICK));
         if (i < total && $urandom_range(99) < 6) pending_words.push_back(random_word(MODE_START));
      end
      repeat ($urandom_range(3)) push_word(random_word(MODE_TICK));
   endtask

   task automatic random_phase(int unsigned tx_pct, int unsigned rx_pct, bit with_hold);
      int unsigned first;
      wait_all_answered();
      write_reg(CSR_SHORT_TICKS, $urandom_range(3));
      write_reg(CSR_LONG_TICKS, $urandom_range(3));
      write_reg(CSR_SYNC_GAP_TICKS, $urandom_range(3));
      tx_gap_pct   = tx_pct;
      rx_stall_pct = rx_pct;
      first = words_queued;
      while (words_queued - first < PHASE_WORDS) begin
         if ($urandom_range(99) < 80) begin
            queue_burst();
         end else if ($urandom_range(1) != 0) begin
            // tick while idle
            push_word(random_word(MODE_TICK));
         end else begin
            // start with nothing to send
            push_word(make_word(MODE_START, $urandom_range(3), $urandom_range(3),
                                $urandom_range(1), 0));
         end
      end
      // receiver sits still while words keep coming, so the input backs up
      if (with_hold) hold_go++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle tick with every field at its top, then a zero-repeat start
      push_word(make_word(MODE_TICK, 2'd3, 2'd3, 1'b1, 8'd255));
      push_word(make_word(MODE_START, 2'd3, 2'd3, 1'b1, 8'd0));
      push_word(make_word(MODE_TICK, 2'd0, 2'd0, 1'b0, 8'd0));
      // real burst at reset durations, with a start while busy
      push_word(make_word(MODE_START, 2'd2, 2'd1, 1'b1, 8'd1));
      repeat (3) push_word(make_word(MODE_TICK, 2'd0, 2'd0, 1'b0, 8'd0));
      push_word(make_word(MODE_START, 2'd0, 2'd0, 1'b0, 8'd255));
      repeat (2) push_word(make_word(MODE_TICK, 2'd3, 2'd3, 1'b1, 8'd255));
      wait_all_answered();

      // durations changed mid-burst: top values, then zero (one tick)
      write_reg(CSR_SHORT_TICKS, 14'h3fff);
      write_reg(CSR_LONG_TICKS, 14'h3fff);
      write_reg(CSR_SYNC_GAP_TICKS, 14'h3fff);
      repeat (3) push_word(make_word(MODE_TICK, 2'd1, 2'd2, 1'b0, 8'd128));
      wait_all_answered();
      write_reg(CSR_SPARE, 14'h3fff);
      write_reg(CSR_SHORT_TICKS, 14'd0);
      write_reg(CSR_LONG_TICKS, 14'd0);
      write_reg(CSR_SYNC_GAP_TICKS, 14'd0);

      // run the burst out before the random part
      while (burst_on) begin
         repeat (16) push_word(random_word(MODE_TICK));
         wait_all_answered();
      end

      random_phase(0, 0, 1'b1);
      random_phase(82, 0, 1'b0);
      random_phase(0, 82, 1'b0);
      random_phase(15, 15, 1'b0);

      wait_all_answered();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0)
         $display("[tristate_remote_frame_encoder] OK");
      else
         $display("[tristate_remote_frame_encoder] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[tristate_remote_frame_encoder] ERROR");
      $finish;
   end

endmodule
